// ===== hw/rtl/bik_pkg.sv =====
// Shared constants for the bicubic interpolation kernel.
package bik_pkg;

   // Taps per axis of the cubic convolution kernel.
   localparam int TAPS = 4;

   // Axis selectors for the weight generator.
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXES   = 2;

endpackage

// ===== hw/rtl/bik_weights.sv =====
// Weight generator: saturates both fractions and builds four cubic weights per axis.
module bik_weights import bik_pkg::*; #(
   parameter int SAMPLE_BITS = 8,
   parameter int FRAC_BITS   = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [TAPS*TAPS*SAMPLE_BITS-1:0]        rows_in,
   input  logic [FRAC_BITS:0]                      frac_x,
   input  logic [FRAC_BITS:0]                      frac_y,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [TAPS*TAPS*SAMPLE_BITS-1:0]        rows_out,
   output logic signed [3*FRAC_BITS+2:0]           wx_out [TAPS],
   output logic signed [3*FRAC_BITS+2:0]           wy_out [TAPS]
);

   localparam int FW  = FRAC_BITS + 1;
   localparam int F2W = 2 * FRAC_BITS + 1;
   localparam int F3W = 3 * FRAC_BITS + 1;
   localparam int WB  = 3 * FRAC_BITS + 3;
   localparam int IB  = 3 * FRAC_BITS + 6;
   localparam int RB  = TAPS * TAPS * SAMPLE_BITS;
   localparam logic [FW-1:0] FONE = FW'(1) << FRAC_BITS;

   logic [2:0] v_ff;
   logic [2:0] en;

   logic [FW-1:0]  raw       [AXES];
   logic [FW-1:0]  fsat_in   [AXES];
   logic [F2W-1:0] f2_in     [AXES];
   logic [F3W-1:0] f3_in     [AXES];

   logic [FW-1:0]  f1_ff     [AXES];
   logic [F2W-1:0] f2_1_ff   [AXES];
   logic [FW-1:0]  f2s_ff    [AXES];
   logic [F2W-1:0] f2_2_ff   [AXES];
   logic [F3W-1:0] f3_2_ff   [AXES];

   logic [IB-1:0]  ta        [AXES];
   logic [IB-1:0]  tb        [AXES];
   logic [IB-1:0]  tc        [AXES];
   logic [IB-1:0]  td        [AXES];
   logic [IB-1:0]  wfull_in  [AXES][TAPS];
   logic signed [WB-1:0] w_ff [AXES][TAPS];

   logic [RB-1:0]  rows_ff   [3];

   always_comb begin
      en[2] = !v_ff[2] || out_ready;
      en[1] = !v_ff[1] || en[2];
      en[0] = !v_ff[0] || en[1];
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
      end
   end

   // stage 1: saturate, square
   always_comb begin
      raw[AXIS_X] = frac_x;
      raw[AXIS_Y] = frac_y;
      for (int a = 0; a < AXES; a++) begin
         fsat_in[a] = (raw[a] > FONE) ? FONE : raw[a];
         f2_in[a]   = fsat_in[a] * fsat_in[a];
      end
   end

   // stage 2: cube
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         f3_in[a] = f2_1_ff[a] * f1_ff[a];
      end
   end

   // stage 3: weights scaled by 2*S^3, modular arithmetic then trimmed
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         ta[a] = IB'(f3_2_ff[a]);
         tb[a] = IB'(f2_2_ff[a]) << FRAC_BITS;
         tc[a] = IB'(f2s_ff[a]) << (2 * FRAC_BITS);
         td[a] = IB'(1) << (3 * FRAC_BITS);
         wfull_in[a][0] = (tb[a] << 1) - ta[a] - tc[a];
         wfull_in[a][1] = (ta[a] << 1) + ta[a] - ((tb[a] << 2) + tb[a]) + (td[a] << 1);
         wfull_in[a][2] = (tb[a] << 2) + tc[a] - ((ta[a] << 1) + ta[a]);
         wfull_in[a][3] = ta[a] - tb[a];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rows_ff[0] <= rows_in;
         for (int a = 0; a < AXES; a++) begin
            f1_ff[a]   <= fsat_in[a];
            f2_1_ff[a] <= f2_in[a];
         end
      end
      if (en[1]) begin
         rows_ff[1] <= rows_ff[0];
         for (int a = 0; a < AXES; a++) begin
            f2s_ff[a]  <= f1_ff[a];
            f2_2_ff[a] <= f2_1_ff[a];
            f3_2_ff[a] <= f3_in[a];
         end
      end
      if (en[2]) begin
         rows_ff[2] <= rows_ff[1];
         for (int a = 0; a < AXES; a++) begin
            for (int k = 0; k < TAPS; k++) begin
               w_ff[a][k] <= $signed(wfull_in[a][k][WB-1:0]);
            end
         end
      end
   end

   assign rows_out = rows_ff[2];

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         wx_out[k] = w_ff[AXIS_X][k];
         wy_out[k] = w_ff[AXIS_Y][k];
      end
   end

endmodule

// ===== hw/rtl/bik_row_filter.sv =====
// Horizontal filter: sixteen tap products, then one sum per row.
module bik_row_filter import bik_pkg::*; #(
   parameter int SAMPLE_BITS = 8,
   parameter int FRAC_BITS   = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [TAPS*TAPS*SAMPLE_BITS-1:0]        rows_in,
   input  logic signed [3*FRAC_BITS+2:0]           wx_in [TAPS],
   input  logic signed [3*FRAC_BITS+2:0]           wy_in [TAPS],
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic signed [3*FRAC_BITS+SAMPLE_BITS+2:0] h_out [TAPS],
   output logic signed [3*FRAC_BITS+2:0]           wy_out [TAPS]
);

   localparam int WB = 3 * FRAC_BITS + 3;
   localparam int HB = 3 * FRAC_BITS + SAMPLE_BITS + 3;
   localparam int PB = WB + SAMPLE_BITS + 1;

   logic [1:0] v_ff;
   logic [1:0] en;

   logic signed [PB-1:0] prod_in [TAPS][TAPS];
   logic signed [PB-1:0] prod_ff [TAPS][TAPS];
   logic signed [PB-1:0] hsum_in [TAPS];
   logic signed [HB-1:0] h_ff    [TAPS];
   logic signed [WB-1:0] wy_a_ff [TAPS];
   logic signed [WB-1:0] wy_b_ff [TAPS];

   always_comb begin
      en[1] = !v_ff[1] || out_ready;
      en[0] = !v_ff[0] || en[1];
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
      end
   end

   always_comb begin
      for (int r = 0; r < TAPS; r++) begin
         for (int c = 0; c < TAPS; c++) begin
            prod_in[r][c] = $signed({1'b0, rows_in[(r*TAPS+c)*SAMPLE_BITS +: SAMPLE_BITS]})
                            * wx_in[c];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < TAPS; r++) begin
         hsum_in[r] = '0;
         for (int c = 0; c < TAPS; c++) begin
            hsum_in[r] = hsum_in[r] + prod_ff[r][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         wy_a_ff <= wy_in;
      end
      if (en[1]) begin
         for (int r = 0; r < TAPS; r++) begin
            h_ff[r] <= hsum_in[r][HB-1:0];
         end
         wy_b_ff <= wy_a_ff;
      end
   end

   assign h_out  = h_ff;
   assign wy_out = wy_b_ff;

endmodule

// ===== hw/rtl/bik_vertical.sv =====
// Vertical combine: row weighting, total, scaling and clamp into the output register.
module bik_vertical import bik_pkg::*; #(
   parameter int SAMPLE_BITS = 8,
   parameter int FRAC_BITS   = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [3*FRAC_BITS+SAMPLE_BITS+2:0] h_in [TAPS],
   input  logic signed [3*FRAC_BITS+2:0]           wy_in [TAPS],
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [SAMPLE_BITS-1:0]                  pixel_out
);

   localparam int WB = 3 * FRAC_BITS + 3;
   localparam int HB = 3 * FRAC_BITS + SAMPLE_BITS + 3;
   localparam int MB = WB + HB;
   localparam int TB = 6 * FRAC_BITS + SAMPLE_BITS + 5;
   localparam int SH = 6 * FRAC_BITS + 2;
   localparam int QB = TB - SH;

   logic [2:0] v_ff;
   logic [2:0] en;

   logic signed [MB-1:0] m_in  [TAPS];
   logic signed [MB-1:0] m_ff  [TAPS];
   logic signed [MB-1:0] sum_in;
   logic signed [TB-1:0] total_ff;
   logic [QB-1:0]        quot;
   logic                 over;
   logic [SAMPLE_BITS-1:0] pixel_in;
   logic [SAMPLE_BITS-1:0] pixel_ff;

   always_comb begin
      en[2] = !v_ff[2] || out_ready;
      en[1] = !v_ff[1] || en[2];
      en[0] = !v_ff[0] || en[1];
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_comb begin
      for (int r = 0; r < TAPS; r++) begin
         m_in[r] = wy_in[r] * h_in[r];
      end
   end

   always_comb begin
      sum_in = '0;
      for (int r = 0; r < TAPS; r++) begin
         sum_in = sum_in + m_ff[r];
      end
   end

   // truncating divide by 4*S^6 is a plain shift once the sign is known
   always_comb begin
      quot = total_ff[TB-1:SH];
      over = |quot[QB-1:SAMPLE_BITS];
      if (total_ff[TB-1]) begin
         pixel_in = '0;
      end else if (over) begin
         pixel_in = '1;
      end else begin
         pixel_in = quot[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) m_ff <= m_in;
      if (en[1]) total_ff <= sum_in[TB-1:0];
      if (en[2]) pixel_ff <= pixel_in;
   end

   assign pixel_out = pixel_ff;

endmodule

// ===== hw/rtl/bicubic_interpolation_kernel_top.sv =====
// Top level of the bicubic interpolation kernel (cubic convolution, a = -1/2).
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  rows top..bottom, frac_x, frac_y
//  rsp      out        rsp_tvalid/rsp_tready  pixel_value
//
// One request per clock sustained while rsp_tready stays high; 3 weight, 2 row filter
// and 3 vertical stages, the last ending in the output register.
// Synchronous reset clears the stage valid bits only.
// Each stage advances when empty or when the next one moves, so a stalled
// output fills bubbles before req_tready drops.
module bicubic_interpolation_kernel_top import bik_pkg::*; #(
   parameter int SAMPLE_BITS = 8,
   parameter int FRAC_BITS   = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // row_top, row_upper, row_lower, row_bottom, frac_x, frac_y, zero pad
   input  logic [((TAPS*TAPS*SAMPLE_BITS+2*(FRAC_BITS+1)+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pixel_value, zero pad
   output logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int RB  = TAPS * TAPS * SAMPLE_BITS;
   localparam int FW  = FRAC_BITS + 1;
   localparam int WB  = 3 * FRAC_BITS + 3;
   localparam int HB  = 3 * FRAC_BITS + SAMPLE_BITS + 3;
   localparam int OUT_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   logic                 w_valid;
   logic                 w_ready;
   logic [RB-1:0]        w_rows;
   logic signed [WB-1:0] w_wx [TAPS];
   logic signed [WB-1:0] w_wy [TAPS];

   logic                 h_valid;
   logic                 h_ready;
   logic signed [HB-1:0] h_rows [TAPS];
   logic signed [WB-1:0] h_wy [TAPS];

   logic [SAMPLE_BITS-1:0] pixel_value;

   bik_weights #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_weights (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .rows_in   (req_tdata[RB-1:0]),
      .frac_x    (req_tdata[RB +: FW]),
      .frac_y    (req_tdata[RB+FW +: FW]),
      .out_valid (w_valid),
      .out_ready (w_ready),
      .rows_out  (w_rows),
      .wx_out    (w_wx),
      .wy_out    (w_wy)
   );

   bik_row_filter #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_row_filter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (w_valid),
      .in_ready  (w_ready),
      .rows_in   (w_rows),
      .wx_in     (w_wx),
      .wy_in     (w_wy),
      .out_valid (h_valid),
      .out_ready (h_ready),
      .h_out     (h_rows),
      .wy_out    (h_wy)
   );

   bik_vertical #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_vertical (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_valid),
      .in_ready  (h_ready),
      .h_in      (h_rows),
      .wy_in     (h_wy),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .pixel_out (pixel_value)
   );

   assign rsp_tdata = OUT_BITS'(pixel_value);

endmodule

// ===== verif/tb_bicubic_interpolation_kernel_top.sv =====
// Self-checking testbench for the bicubic interpolation kernel top level.
module tb_bicubic_interpolation_kernel_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS  = 8;
   localparam int FRAC_BITS    = 8;
   localparam int REQ_BITS     = 152;
   localparam int RSP_BITS     = 8;
   localparam int LATENCY      = 8;
   localparam int RANDOM_ITEMS = 900;
   localparam int QUIET_ITEMS  = 150;
   localparam int STALL_LIMIT  = 1000;
   localparam longint FRAC_ONE = 64'sd1 << FRAC_BITS;
   localparam int FRAC_MAX     = (1 << (FRAC_BITS + 1)) - 1;

   // row_top, row_upper, row_lower, row_bottom, frac_x, frac_y, zero pad
   typedef struct packed {
      logic [5:0]  pad;
      logic [8:0]  frac_y;
      logic [8:0]  frac_x;
      logic [31:0] row_bottom;
      logic [31:0] row_lower;
      logic [31:0] row_upper;
      logic [31:0] row_top;
   } pixel_request_type;

   class pixel_scoreboard;
      logic [7:0] expected_pixels[$];
      int         failures;

      function new();
         failures = 0;
      endfunction

      // Keys cubic weight for one tap, scaled by 2*S^3
      function longint keys_weight(int tap, logic [8:0] frac);
         longint f, s, f2, f3;
         f  = (longint'(frac) > FRAC_ONE) ? FRAC_ONE : longint'(frac);
         s  = FRAC_ONE;
         f2 = f * f;
         f3 = f2 * f;
         case (tap)
            0: return -f3 + 2 * f2 * s - f * s * s;
            1: return 3 * f3 - 5 * f2 * s + 2 * s * s * s;
            2: return -3 * f3 + 4 * f2 * s + f * s * s;
            default: return f3 - f2 * s;
         endcase
      endfunction

      function longint filter_row(logic [31:0] row, logic [8:0] frac_x);
         longint sum;
         sum = 0;
         for (int j = 0; j < 4; j++) begin
            sum += longint'({56'd0, row[j*SAMPLE_BITS +: SAMPLE_BITS]}) *
                   keys_weight(j, frac_x);
         end
         return sum;
      endfunction

      function logic [7:0] interpolate(pixel_request_type item);
         logic signed [127:0] total, wy, hx, quotient;
         logic [31:0]         rows [4];
         rows  = '{item.row_top, item.row_upper, item.row_lower, item.row_bottom};
         total = '0;
         for (int i = 0; i < 4; i++) begin
            wy    = keys_weight(i, item.frac_y);
            hx    = filter_row(rows[i], item.frac_x);
            total = total + wy * hx;
         end
         if (total < 0) return 8'd0;
         quotient = total >>> (6 * FRAC_BITS + 2);
         if (quotient > 255) return 8'd255;
         return quotient[7:0];
      endfunction

      function void note_request(logic [REQ_BITS-1:0] data);
         expected_pixels.push_back(interpolate(pixel_request_type'(data)));
      endfunction

      function void check_response(logic [RSP_BITS-1:0] data);
         logic [7:0] expected;
         if (expected_pixels.size() == 0) begin
            $error("pixel_value: no request outstanding, got %0d", data[7:0]);
            failures++;
            return;
         end
         expected = expected_pixels.pop_front();
         if (data[7:0] !== expected) begin
            $error("pixel_value: expected %0d, got %0d", expected, data[7:0]);
            failures++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;

   pixel_scoreboard sb = new();
   bit              quiet_tail  = 1'b0;
   int              gap_percent = 0;
   int              idle_cycles = 0;

   bicubic_interpolation_kernel_top #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side back-pressure: bursts of stalls, long ready stretches now and then
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (quiet_tail) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 14);
            repeat (n) @(posedge clock);
            if (!quiet_tail) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 14)) @(posedge clock);
            end
         end
      end
   end

   task automatic send_pixel(input pixel_request_type item);
      if (!quiet_tail && $urandom_range(0, 99) < gap_percent) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      item.pad = '0;
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_directed(input logic [31:0] top, input logic [31:0] upper,
                                input logic [31:0] lower, input logic [31:0] bottom,
                                input int fx, input int fy);
      pixel_request_type item;
      item = '{pad: '0, frac_y: fy[8:0], frac_x: fx[8:0], row_bottom: bottom,
               row_lower: lower, row_upper: upper, row_top: top};
      send_pixel(item);
   endtask

   function automatic logic [31:0] random_row();
      logic [31:0] row;
      logic [7:0]  base;
      row = $urandom;
      case ($urandom_range(0, 3))
         0: ;
         1: for (int j = 0; j < 4; j++) row[j*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         2: begin
            base = 8'($urandom);
            for (int j = 0; j < 4; j++) begin
               row[j*8 +: 8] = base;
               base = base + 8'($urandom_range(0, 15)) - 8'd7;
            end
         end
         default: begin
            for (int j = 0; j < 4; j++) begin
               case ($urandom_range(0, 2))
                  0: row[j*8 +: 8] = 8'h00;
                  1: row[j*8 +: 8] = 8'hFF;
                  default: ;
               endcase
            end
         end
      endcase
      return row;
   endfunction

   function automatic logic [8:0] random_frac();
      case ($urandom_range(0, 9))
         0: return 9'(FRAC_ONE);
         1: return 9'd0;
         2: return 9'($urandom_range(int'(FRAC_ONE) + 1, FRAC_MAX));
         default: return 9'($urandom_range(0, int'(FRAC_ONE)));
      endcase
   endfunction

   initial begin
      pixel_request_type item;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_percent = 30;
      send_directed(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 0, 0);
      send_directed(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 256, 256);
      send_directed(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0);
      send_directed(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 128, 128);
      // overshoot and undershoot along x, then along y, then along both
      send_directed(32'h00FFFF00, 32'h00FFFF00, 32'h00FFFF00, 32'h00FFFF00, 128, 0);
      send_directed(32'hFF0000FF, 32'hFF0000FF, 32'hFF0000FF, 32'hFF0000FF, 128, 0);
      send_directed(32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 0, 128);
      send_directed(32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'hFFFFFFFF, 0, 128);
      send_directed(32'h00000000, 32'h00FFFF00, 32'h00FFFF00, 32'h00000000, 128, 128);
      send_directed(32'hFF0000FF, 32'h00FFFF00, 32'h00FFFF00, 32'hFF0000FF, 100, 160);
      // fractions above one saturate; in-range and out-of-range fractions follow
      send_directed(32'h44332211, 32'h88776655, 32'hCCBBAA99, 32'h00FFEEDD, 257, 511);
      send_directed(32'h44332211, 32'h88776655, 32'hCCBBAA99, 32'h00FFEEDD, 511, 300);
      send_directed(32'h44332211, 32'h88776655, 32'hCCBBAA99, 32'h00FFEEDD, 256, 0);
      send_directed(32'h44332211, 32'h88776655, 32'hCCBBAA99, 32'h00FFEEDD, 1, 255);
      send_directed(32'h44332211, 32'h88776655, 32'hCCBBAA99, 32'h00FFEEDD, 255, 1);
      send_directed(32'h40302010, 32'h50403020, 32'h60504030, 32'h70605040, 64, 192);
      send_directed(32'h5A5AA5A5, 32'hA5A55A5A, 32'h0F0FF0F0, 32'hF0F00F0F, 511, 511);
      send_directed(32'h01020304, 32'hFEFDFCFB, 32'h7F80817E, 32'h80808080, 192, 64);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: gap_percent = 0;
               1: gap_percent = 20;
               default: gap_percent = 60;
            endcase
         end
         if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
         item.pad        = '0;
         item.row_top    = random_row();
         item.row_upper  = random_row();
         item.row_lower  = random_row();
         item.row_bottom = random_row();
         item.frac_x     = random_frac();
         item.frac_y     = random_frac();
         send_pixel(item);
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
